// ===== rtl/core/spq_pkg.sv =====
// Shared types, codes and defaults of the stable priority request queue.
`default_nettype none

package spq_pkg;

   // Default number of queue entries.
   localparam int SPQ_DEPTH = 16;

   // Field widths of one item.
   localparam int CMD_W    = 2;
   localparam int PRIO_W   = 4;
   localparam int CLIENT_W = 16;
   localparam int PID_W    = 22;
   localparam int XFORM_W  = 4;
   localparam int HANDLE_W = 16;
   localparam int STATUS_W = 2;
   localparam int OCC_W    = 5;

   // Command codes.
   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_POP    = 2'd2;
   localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd3;

   // Status codes.
   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_NOTFOUND = 2'd3;

   // One stored queue entry, 62 bits.
   typedef struct packed {
      logic [PRIO_W-1:0]   prio;
      logic [CLIENT_W-1:0] client;
      logic [PID_W-1:0]    pid;
      logic [XFORM_W-1:0]  transforms;
      logic [HANDLE_W-1:0] handle;
   } entry_type;

endpackage

`default_nettype wire

// ===== rtl/core/spq_mem.sv =====
// Entry store: one write port and one read port with registered read data.
`default_nettype none

module spq_mem #(
   parameter int DEPTH = spq_pkg::SPQ_DEPTH
) (
   input  wire logic                     clock,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output spq_pkg::entry_type            rd_data,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire spq_pkg::entry_type       wr_data
);
   import spq_pkg::*;

   entry_type mem_array [DEPTH];
   entry_type rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_array[wr_addr] <= wr_data;
      end
   end

   // Read port with registered read data.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_array[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/stable_priority_request_queue_core.sv =====
// Top level of the stable priority request queue: command sequencer around the entry store.
`default_nettype none

// Stable priority request queue.
// A command item is taken at a rising edge with start high and busy low; busy stays
// high while the command walks the entry store. Exactly one result item follows each
// command: rsp_valid is high for one cycle with status, the returned entry and the
// occupancy after the command. The receiver cannot stall, so results are never held.
// Steps of each command, after which the result item is registered:
//   insert into an empty or full queue, and any command on an empty queue: no walk;
//   insert: each entry of lower priority moves up by one, then the new entry is written;
//   lookup: entries are compared from the head up to the match (all of them if none);
//   remove and pop: the compare walk, then each entry after the match moves down by one.
// The pace is set by the single read and single write port of the entry store: the
// sequencer moves one entry per cycle, reading the next entry while it writes the
// previous one, so a read and a write never meet at the same address.
// Reset clears the entry count and the sequencer; the store itself needs no clearing
// pass, since only entries below the count are ever read. The block is ready for a
// command as soon as reset is released.
module stable_priority_request_queue_core #(
   parameter int DEPTH = spq_pkg::SPQ_DEPTH
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   output logic                                busy,
   input  wire logic [spq_pkg::CMD_W-1:0]      req_command,
   input  wire logic [spq_pkg::PRIO_W-1:0]     req_priority_req,
   input  wire logic [spq_pkg::CLIENT_W-1:0]   req_client_id,
   input  wire logic [spq_pkg::PID_W-1:0]      req_request_pid,
   input  wire logic [spq_pkg::XFORM_W-1:0]    req_transform_count,
   input  wire logic [spq_pkg::HANDLE_W-1:0]   req_payload_handle,
   output logic                                rsp_valid,
   output logic [spq_pkg::STATUS_W-1:0]        rsp_status,
   output logic [spq_pkg::PRIO_W-1:0]          rsp_found_priority,
   output logic [spq_pkg::CLIENT_W-1:0]        rsp_found_client,
   output logic [spq_pkg::PID_W-1:0]           rsp_found_pid,
   output logic [spq_pkg::XFORM_W-1:0]         rsp_found_transforms,
   output logic [spq_pkg::HANDLE_W-1:0]        rsp_found_handle,
   output logic [spq_pkg::OCC_W-1:0]           rsp_occupancy
);
   import spq_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   // Sequencer states.
   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_INS   = 2'd1;
   localparam logic [1:0] S_SCAN  = 2'd2;
   localparam logic [1:0] S_SHIFT = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [CMD_W-1:0] cmd_ff, cmd_in;
   entry_type        new_ff, new_in;
   entry_type        got_ff, got_in;
   logic [AW-1:0]    ptr_ff, ptr_in;
   logic [CW-1:0]    count_ff, count_in;

   logic             rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   entry_type        rsp_entry_ff;
   logic [OCC_W-1:0] rsp_occ_ff;

   logic             rd_en, wr_en;
   logic [AW-1:0]    rd_addr, wr_addr;
   entry_type        rd_entry, wr_data, req_entry;

   logic                finish;
   logic [STATUS_W-1:0] fin_status;
   entry_type           fin_entry;
   logic [CW+OCC_W-1:0] occ_wide;

   logic [CW-1:0]    ptr_next, ptr_next2;
   logic             scan_last, shift_last, scan_match;

   assign req_entry = '{prio: req_priority_req, client: req_client_id,
                        pid: req_request_pid, transforms: req_transform_count,
                        handle: req_payload_handle};

   spq_mem #(
      .DEPTH(DEPTH)
   ) u_mem (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_entry),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   // Positions one and two entries on from the pointer, at count width.
   assign ptr_next   = CW'(ptr_ff) + CW'(1);
   assign ptr_next2  = CW'(ptr_ff) + CW'(2);
   assign scan_last  = (ptr_next == count_ff);
   assign shift_last = (ptr_next2 == count_ff);
   assign scan_match = (cmd_ff == CMD_POP) || (rd_entry.client == new_ff.client);

   // Command sequencer: at most one entry read and at most one entry written per cycle.
   always_comb begin
      state_in   = state_ff;
      cmd_in     = cmd_ff;
      new_in     = new_ff;
      got_in     = got_ff;
      ptr_in     = ptr_ff;
      count_in   = count_ff;
      rd_en      = 1'b0;
      rd_addr    = '0;
      wr_en      = 1'b0;
      wr_addr    = '0;
      wr_data    = new_ff;
      finish     = 1'b0;
      fin_status = STATUS_OK;
      fin_entry  = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd_in = req_command;
               new_in = req_entry;
               if (req_command == CMD_INSERT) begin
                  if (count_ff == CW'(DEPTH)) begin
                     finish     = 1'b1;
                     fin_status = STATUS_FULL;
                  end else if (count_ff == '0) begin
                     wr_en    = 1'b1;
                     wr_data  = req_entry;
                     count_in = CW'(1);
                     finish   = 1'b1;
                  end else begin
                     rd_en    = 1'b1;
                     rd_addr  = AW'(count_ff - CW'(1));
                     ptr_in   = AW'(count_ff);
                     state_in = S_INS;
                  end
               end else if (count_ff == '0) begin
                  finish     = 1'b1;
                  fin_status = STATUS_EMPTY;
               end else begin
                  rd_en    = 1'b1;
                  ptr_in   = '0;
                  state_in = S_SCAN;
               end
            end
         end
         S_INS: begin
            // Walk down from the tail, moving lower priority entries up by one.
            if (ptr_ff == '0) begin
               wr_en    = 1'b1;
               count_in = count_ff + CW'(1);
               finish   = 1'b1;
               state_in = S_IDLE;
            end else if (rd_entry.prio < new_ff.prio) begin
               wr_en   = 1'b1;
               wr_addr = ptr_ff;
               wr_data = rd_entry;
               ptr_in  = ptr_ff - AW'(1);
               if (ptr_ff != AW'(1)) begin
                  rd_en   = 1'b1;
                  rd_addr = ptr_ff - AW'(1) - AW'(1);
               end
            end else begin
               wr_en    = 1'b1;
               wr_addr  = ptr_ff;
               count_in = count_ff + CW'(1);
               finish   = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_SCAN: begin
            // Compare the entry at the pointer while fetching the next one.
            if (!scan_last) begin
               rd_en   = 1'b1;
               rd_addr = AW'(ptr_next);
            end
            if (scan_match) begin
               if (cmd_ff == CMD_LOOKUP) begin
                  finish    = 1'b1;
                  fin_entry = rd_entry;
                  state_in  = S_IDLE;
               end else if (scan_last) begin
                  count_in  = count_ff - CW'(1);
                  finish    = 1'b1;
                  fin_entry = rd_entry;
                  state_in  = S_IDLE;
               end else begin
                  got_in   = rd_entry;
                  state_in = S_SHIFT;
               end
            end else if (scan_last) begin
               finish     = 1'b1;
               fin_status = STATUS_NOTFOUND;
               state_in   = S_IDLE;
            end else begin
               ptr_in = AW'(ptr_next);
            end
         end
         S_SHIFT: begin
            // Close the gap: the entry after the pointer moves down by one.
            wr_en   = 1'b1;
            wr_addr = ptr_ff;
            wr_data = rd_entry;
            if (shift_last) begin
               count_in  = count_ff - CW'(1);
               finish    = 1'b1;
               fin_entry = got_ff;
               state_in  = S_IDLE;
            end else begin
               rd_en   = 1'b1;
               rd_addr = AW'(ptr_next2);
               ptr_in  = AW'(ptr_next);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Occupancy is the new count masked to the result width.
   assign occ_wide = {{OCC_W{1'b0}}, count_in};

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= finish;
      end
   end

   // Working registers and the result item.
   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      new_ff <= new_in;
      got_ff <= got_in;
      ptr_ff <= ptr_in;
      if (finish) begin
         rsp_status_ff <= fin_status;
         rsp_entry_ff  <= fin_entry;
         rsp_occ_ff    <= occ_wide[OCC_W-1:0];
      end
   end

   assign busy                 = (state_ff != S_IDLE);
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_found_priority   = rsp_entry_ff.prio;
   assign rsp_found_client     = rsp_entry_ff.client;
   assign rsp_found_pid        = rsp_entry_ff.pid;
   assign rsp_found_transforms = rsp_entry_ff.transforms;
   assign rsp_found_handle     = rsp_entry_ff.handle;
   assign rsp_occupancy        = rsp_occ_ff;

endmodule

`default_nettype wire

// ===== test/tb_stable_priority_request_queue_core.sv =====
// Self-checking testbench for the stable priority request queue core.
`timescale 1ns / 100ps

module tb_stable_priority_request_queue_core;
   import spq_pkg::*;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int RANDOM_ITEMS  = 550;
   localparam int SEGMENT_LEN   = 50;
   localparam int SETTLE_CYCLES = 40;
   localparam int MAX_GAP       = 18;

   // One command item as it waits in the backlog, with its idle gap.
   typedef struct {
      logic [CMD_W-1:0]    command;
      logic [PRIO_W-1:0]   prio;
      logic [CLIENT_W-1:0] client;
      logic [PID_W-1:0]    pid;
      logic [XFORM_W-1:0]  transforms;
      logic [HANDLE_W-1:0] handle;
      int unsigned         gap;
      bit                  drain;
   } queue_cmd_type;

   // One result item as the block should report it.
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [PRIO_W-1:0]   prio;
      logic [CLIENT_W-1:0] client;
      logic [PID_W-1:0]    pid;
      logic [XFORM_W-1:0]  transforms;
      logic [HANDLE_W-1:0] handle;
      logic [OCC_W-1:0]    occupancy;
   } queue_reply_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic [CMD_W-1:0]    req_command = CMD_INSERT;
   logic [PRIO_W-1:0]   req_priority_req = '0;
   logic [CLIENT_W-1:0] req_client_id = '0;
   logic [PID_W-1:0]    req_request_pid = '0;
   logic [XFORM_W-1:0]  req_transform_count = '0;
   logic [HANDLE_W-1:0] req_payload_handle = '0;
   logic                rsp_valid;
   logic [STATUS_W-1:0] rsp_status;
   logic [PRIO_W-1:0]   rsp_found_priority;
   logic [CLIENT_W-1:0] rsp_found_client;
   logic [PID_W-1:0]    rsp_found_pid;
   logic [XFORM_W-1:0]  rsp_found_transforms;
   logic [HANDLE_W-1:0] rsp_found_handle;
   logic [OCC_W-1:0]    rsp_occupancy;

   queue_cmd_type   pending_cmds[$];
   queue_reply_type predicted_replies[$];
   entry_type       shadow_queue[$];
   queue_cmd_type   staged_cmd;
   queue_cmd_type   on_port;
   bit           staged = 1'b0;
   int unsigned  gap_left = 0;
   int unsigned  accepted_count = 0;
   int unsigned  total_cmds = 0;
   int unsigned  mismatches = 0;
   int unsigned  cycle_count = 0;

   stable_priority_request_queue_core #(
      .DEPTH(SPQ_DEPTH)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_command(req_command),
      .req_priority_req(req_priority_req),
      .req_client_id(req_client_id),
      .req_request_pid(req_request_pid),
      .req_transform_count(req_transform_count),
      .req_payload_handle(req_payload_handle),
      .rsp_valid(rsp_valid),
      .rsp_status(rsp_status),
      .rsp_found_priority(rsp_found_priority),
      .rsp_found_client(rsp_found_client),
      .rsp_found_pid(rsp_found_pid),
      .rsp_found_transforms(rsp_found_transforms),
      .rsp_found_handle(rsp_found_handle),
      .rsp_occupancy(rsp_occupancy)
   );

   // Free-running clock with a 2 ns period.
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Applies one command to the shadow queue and returns the result it should give.
   function automatic queue_reply_type serve_command(input queue_cmd_type c);
      queue_reply_type r;
      entry_type    e;
      int           pos;
      r   = '0;
      pos = -1;
      if (c.command == CMD_INSERT) begin
         if (shadow_queue.size() >= SPQ_DEPTH) begin
            r.status = STATUS_FULL;
         end else begin
            e.prio       = c.prio;
            e.client     = c.client;
            e.pid        = c.pid;
            e.transforms = c.transforms;
            e.handle     = c.handle;
            // A new entry goes behind every entry of equal or higher priority.
            pos = 0;
            while (pos < shadow_queue.size() && shadow_queue[pos].prio >= c.prio) pos++;
            shadow_queue.insert(pos, e);
            r.status = STATUS_OK;
         end
      end else if (shadow_queue.size() == 0) begin
         r.status = STATUS_EMPTY;
      end else begin
         if (c.command == CMD_POP) begin
            pos = 0;
         end else begin
            for (int i = 0; i < shadow_queue.size(); i++) begin
               if (pos < 0 && shadow_queue[i].client == c.client) pos = i;
            end
         end
         if (pos < 0) begin
            r.status = STATUS_NOTFOUND;
         end else begin
            e            = shadow_queue[pos];
            r.status     = STATUS_OK;
            r.prio       = e.prio;
            r.client     = e.client;
            r.pid        = e.pid;
            r.transforms = e.transforms;
            r.handle     = e.handle;
            if (c.command != CMD_LOOKUP) shadow_queue.delete(pos);
         end
      end
      r.occupancy = OCC_W'(shadow_queue.size());
      return r;
   endfunction

   // Appends one directed command item with a random idle gap.
   task automatic queue_cmd(input logic [CMD_W-1:0] command, input logic [PRIO_W-1:0] prio,
                            input logic [CLIENT_W-1:0] client, input logic [PID_W-1:0] pid,
                            input logic [XFORM_W-1:0] transforms,
                            input logic [HANDLE_W-1:0] handle);
      queue_cmd_type c;
      c.command    = command;
      c.prio       = prio;
      c.client     = client;
      c.pid        = pid;
      c.transforms = transforms;
      c.handle     = handle;
      c.gap        = $urandom_range(0, MAX_GAP);
      c.drain      = 1'b0;
      pending_cmds.push_back(c);
   endtask

   // Compares one result field and records a mismatch.
   task automatic check_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, actual 0x%0h", field, want, got);
         mismatches++;
      end
   endtask

   // Driver: presents backlog items after their gaps and predicts each accepted item.
   always @(posedge clock) begin : driver
      logic taken;
      logic start_next;
      taken      = start && !busy;
      start_next = start;
      if (reset) begin
         start_next = 1'b0;
      end else begin
         if (taken) begin
            predicted_replies.push_back(serve_command(on_port));
            accepted_count++;
            start_next = 1'b0;
         end
         if (!start_next) begin
            if (!staged && pending_cmds.size() != 0) begin
               staged_cmd = pending_cmds.pop_front();
               gap_left   = staged_cmd.gap;
               staged     = 1'b1;
            end
            // A draining item holds back until every outstanding result is in.
            if (staged && !(staged_cmd.drain && predicted_replies.size() != 0)) begin
               if (gap_left != 0) begin
                  gap_left--;
               end else begin
                  req_command         <= staged_cmd.command;
                  req_priority_req    <= staged_cmd.prio;
                  req_client_id       <= staged_cmd.client;
                  req_request_pid     <= staged_cmd.pid;
                  req_transform_count <= staged_cmd.transforms;
                  req_payload_handle  <= staged_cmd.handle;
                  on_port    = staged_cmd;
                  staged     = 1'b0;
                  start_next = 1'b1;
               end
            end
         end
      end
      start <= start_next;
   end

   // Monitor: checks every result strobe against the oldest prediction.
   always @(posedge clock) begin : monitor
      queue_reply_type want;
      if (!reset && rsp_valid) begin
         if (predicted_replies.size() == 0) begin
            $error("result with no command outstanding: status %0d", rsp_status);
            mismatches++;
         end else begin
            want = predicted_replies.pop_front();
            check_field("status", 32'(want.status), 32'(rsp_status));
            check_field("found_priority", 32'(want.prio), 32'(rsp_found_priority));
            check_field("found_client", 32'(want.client), 32'(rsp_found_client));
            check_field("found_pid", 32'(want.pid), 32'(rsp_found_pid));
            check_field("found_transforms", 32'(want.transforms),
                        32'(rsp_found_transforms));
            check_field("found_handle", 32'(want.handle), 32'(rsp_found_handle));
            check_field("occupancy", 32'(want.occupancy), 32'(rsp_occupancy));
         end
      end
   end

   // Watchdog on the length of the run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("stable_priority_request_queue_core: mismatch");
         $finish;
      end
   end

   // Stimulus: a directed opening, then random segments that alternately fill and drain.
   initial begin : stimulus
      logic [CLIENT_W-1:0] client_pool[8];
      queue_cmd_type       c;
      int unsigned         insert_pct;
      int unsigned         pick;
      bit                  burst;

      // Commands that need an entry, issued on an empty queue.
      queue_cmd(CMD_POP, 4'd0, 16'h0000, '0, '0, '0);
      queue_cmd(CMD_REMOVE, 4'd3, 16'h1234, '0, '0, '0);
      queue_cmd(CMD_LOOKUP, 4'hF, 16'hFFFF, '1, '1, '1);
      // Field extremes, and equal priorities that must keep their arrival order.
      queue_cmd(CMD_INSERT, 4'hF, 16'hFFFF, '1, '1, '1);
      queue_cmd(CMD_INSERT, 4'h0, 16'h0000, '0, '0, '0);
      queue_cmd(CMD_INSERT, 4'h7, 16'h00A1, 22'h2AAAAA, 4'h5, 16'h5A5A);
      queue_cmd(CMD_INSERT, 4'h7, 16'h00A2, 22'h155555, 4'hA, 16'hA5A5);
      queue_cmd(CMD_INSERT, 4'h7, 16'h00A1, 22'h000001, 4'h1, 16'h0001);
      // Lookup and remove, each with a hit on the first match and a miss.
      queue_cmd(CMD_LOOKUP, 4'h0, 16'h00A1, '0, '0, '0);
      queue_cmd(CMD_LOOKUP, 4'h0, 16'h5555, '0, '0, '0);
      queue_cmd(CMD_REMOVE, 4'h0, 16'h00A1, '0, '0, '0);
      queue_cmd(CMD_REMOVE, 4'h0, 16'h7777, '0, '0, '0);
      // Fill to capacity, then insert into the full queue.
      for (int i = 0; i < 12; i++) begin
         queue_cmd(CMD_INSERT, 4'(6 + i % 3), 16'(16'h0100 + i), 22'($urandom),
                   4'($urandom), 16'($urandom));
      end
      queue_cmd(CMD_INSERT, 4'h9, 16'hBEEF, '1, '0, '1);

      // Random part: a small pool of client ids makes lookups and removes hit often.
      for (int i = 0; i < 8; i++) client_pool[i] = 16'($urandom_range(0, 65535));
      insert_pct = 60;
      burst      = 1'b0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % SEGMENT_LEN == 0) begin
            insert_pct = ((n / SEGMENT_LEN) % 2 == 0) ? 65 : 20;
            burst      = ((n / SEGMENT_LEN) % 3 == 2);
         end
         pick = $urandom_range(0, 99);
         if (pick < insert_pct) begin
            c.command = CMD_INSERT;
         end else begin
            case ($urandom_range(0, 2))
               0: c.command = CMD_REMOVE;
               1: c.command = CMD_POP;
               default: c.command = CMD_LOOKUP;
            endcase
         end
         c.prio       = PRIO_W'($urandom);
         c.client     = ($urandom_range(0, 7) == 0) ? CLIENT_W'($urandom)
                                                    : client_pool[$urandom_range(0, 7)];
         c.pid        = PID_W'($urandom);
         c.transforms = XFORM_W'($urandom);
         c.handle     = HANDLE_W'($urandom);
         c.gap        = burst ? 0 : $urandom_range(0, MAX_GAP);
         c.drain      = (n % 97 == 0);
         pending_cmds.push_back(c);
      end
      total_cmds = pending_cmds.size();

      // Single reset at the start of the run.
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Wait until every item is accepted and every result has arrived.
      do @(posedge clock);
      while (accepted_count != total_cmds || predicted_replies.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (predicted_replies.size() != 0) begin
         $error("%0d results never arrived", predicted_replies.size());
         mismatches++;
      end
      if (mismatches == 0) begin
         $display("stable_priority_request_queue_core: match");
      end else begin
         $display("stable_priority_request_queue_core: mismatch");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/spq_pkg.sv
rtl/core/spq_mem.sv
rtl/core/stable_priority_request_queue_core.sv
test/tb_stable_priority_request_queue_core.sv
